// ----- rtl/signed_int_to_decimal_ascii_defines.svh -----
// Assertion macros shared by the signed integer to decimal ASCII block.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication check.
`define SIDA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sida: same-cycle check failed");
// Next-cycle implication check.
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sida: next-cycle check failed");
`else
`define SIDA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SIDA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/sida_pkg.sv -----
// Shared constants, types and functions of the decimal ASCII converter.
package sida_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 6;
   localparam int DIGITS     = 10;
   localparam int BCD_W      = 4 * DIGITS;
   localparam int STEP_BITS  = 4;
   localparam int CONV_STEPS = VALUE_W / STEP_BITS;
   localparam int CNT_W      = $clog2(CONV_STEPS);
   localparam int IDX_W      = $clog2(DIGITS + 1);

   localparam logic [CHAR_W-1:0] CHR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CHR_MINUS = 6'd45;

   typedef enum logic [1:0] {
      IDLE_ST,
      CONV_ST,
      FIRST_ST,
      EMIT_ST
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic first;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

   // Add 3 to every BCD digit of 5 or more, ahead of a left shift.
   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] res;
      res = bcd;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

   // Number of significant digits; zero counts as one digit.
   function automatic logic [IDX_W-1:0] count_digits(input logic [BCD_W-1:0] bcd);
      logic [IDX_W-1:0] n;
      n = IDX_W'(1);
      for (int i = 1; i < DIGITS; i++) begin
         if (bcd[4*i +: 4] != 4'd0) begin
            n = IDX_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

// ----- rtl/sida_channels.sv -----
// Valid/ready channel interfaces for the integer input and the character output.
interface sida_req_if;
   import sida_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sida_rsp_if;
   import sida_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- rtl/sida_ctrl.sv -----
// Controller state machine: sequences conversion steps and character emission.
`include "signed_int_to_decimal_ascii_defines.svh"

module sida_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output sida_pkg::dp_cmd_type    cmd,
   input  sida_pkg::dp_status_type status
);
   import sida_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_ST;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         IDLE_ST: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = CONV_ST;
            end
         end
         CONV_ST: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CONV_STEPS - 1)) begin
               state_in = FIRST_ST;
            end
         end
         FIRST_ST: begin
            cmd.first = 1'b1;
            state_in  = EMIT_ST;
         end
         EMIT_ST: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = IDLE_ST;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE_ST;
         end
      endcase
   end

   `SIDA_ASSERT_NEXT(a_accept_starts_conv, clock, reset, req_valid && req_ready, state_ff == CONV_ST)
   `SIDA_ASSERT_NEXT(a_conv_ends, clock, reset, state_ff == CONV_ST && cnt_ff == CNT_W'(CONV_STEPS - 1), state_ff == FIRST_ST)
   `SIDA_ASSERT_IMPL(a_one_side_open, clock, reset, rsp_valid, !req_ready)
   `SIDA_ASSERT_NEXT(a_last_goes_idle, clock, reset, rsp_valid && rsp_ready && status.last, state_ff == IDLE_ST)
   `SIDA_ASSERT_IMPL(a_single_cmd, clock, reset, 1'b1, $onehot0(cmd))

endmodule

// ----- rtl/sida_dp.sv -----
// Datapath: magnitude, shift-add-3 BCD conversion and the character output register.
module sida_dp (
   input  logic                               clock,
   input  sida_pkg::dp_cmd_type               cmd,
   output sida_pkg::dp_status_type            status,
   input  logic signed [sida_pkg::VALUE_W-1:0] value,
   output logic [sida_pkg::CHAR_W-1:0]        character,
   output logic                               last
);
   import sida_pkg::*;

   logic [VALUE_W-1:0] mag_ff, mag_in, mag_step;
   logic [BCD_W-1:0]   bcd_ff, bcd_in, bcd_step;
   logic               neg_ff, neg_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [IDX_W-1:0]   ndig;
   logic [IDX_W-1:0]   sel_idx;
   logic [3:0]         sel_digit;

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   // Four shift-add-3 steps per cycle.
   always_comb begin
      bcd_step = bcd_ff;
      mag_step = mag_ff;
      for (int s = 0; s < STEP_BITS; s++) begin
         bcd_step = bcd_adjust(bcd_step);
         bcd_step = {bcd_step[BCD_W-2:0], mag_step[VALUE_W-1]};
         mag_step = {mag_step[VALUE_W-2:0], 1'b0};
      end
   end

   assign ndig      = count_digits(bcd_ff);
   assign sel_idx   = cmd.first ? (ndig - IDX_W'(1)) : idx_ff;
   assign sel_digit = bcd_ff[{sel_idx, 2'b00} +: 4];

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      neg_in  = neg_ff;
      idx_in  = idx_ff;
      char_in = char_ff;
      last_in = last_ff;
      if (cmd.load) begin
         neg_in = value[VALUE_W-1];
         mag_in = value[VALUE_W-1] ? (~VALUE_W'(unsigned'(value)) + VALUE_W'(1))
                                   : VALUE_W'(unsigned'(value));
         bcd_in = '0;
      end else if (cmd.step) begin
         mag_in = mag_step;
         bcd_in = bcd_step;
      end else if (cmd.first) begin
         if (neg_ff) begin
            char_in = CHR_MINUS;
            last_in = 1'b0;
            idx_in  = ndig - IDX_W'(1);
         end else begin
            char_in = CHR_ZERO + {2'b00, sel_digit};
            last_in = (ndig == IDX_W'(1));
            idx_in  = ndig - IDX_W'(2);
         end
      end else if (cmd.advance) begin
         char_in = CHR_ZERO + {2'b00, sel_digit};
         last_in = (idx_ff == '0);
         idx_in  = idx_ff - IDX_W'(1);
      end
   end

   assign status.last = last_ff;
   assign character   = char_ff;
   assign last        = last_ff;

endmodule

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// Top level of the signed 32-bit integer to decimal ASCII converter.
//
// Each req transaction carries one signed 32-bit value; the block answers
// with its decimal text on the rsp channel, one ASCII character per
// transaction, most significant first: a '-' for negative values, then the
// digits with leading zeros suppressed (zero gives a single '0'). The most
// negative value comes out as "-2147483648". The final character of each
// number has last set; no terminator follows. One number is handled at a
// time: after the req transaction, the magnitude passes through shift-add-3
// conversion (four magnitude bits per cycle) and the first character is
// loaded into the output register; then the text streams out at up to one
// character per cycle while rsp_ready is high. req_ready is high only while
// no number is in flight.
module signed_int_to_decimal_ascii (
   input logic        clock,
   input logic        reset,
   sida_req_if.sink   req_chan,
   sida_rsp_if.source rsp_chan
);
   import sida_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequence load, conversion steps and character hand-off.
   sida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Hold the magnitude, the BCD digits and the outgoing character.
   sida_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .status    (status),
      .value     (req_chan.value),
      .character (rsp_chan.character),
      .last      (rsp_chan.last)
   );

endmodule
